>>> rtl/core/rmsdma_pkg.sv
`timescale 1ns / 1ps

package rmsdma_pkg;

   // field widths
   localparam int POS_W      = 24;
   localparam int SLOT_W     = 10;
   localparam int TIME_W     = 48;
   localparam int WEIGHT_W   = 17;
   localparam int SQ_W       = 47;
   localparam int D2_W       = 49;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int RMSD_W     = 29;
   localparam int RECIP_SHIFT = 20;

   // Q1.16 one and the weight after reset (about 0.95)
   localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd62259;
   localparam logic [RMSD_W-1:0]   RMSD_MAX     = 29'h1FFFFFFF;

   typedef logic signed [POS_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } avg_word_type;

   // stage enables for the per-axis lanes
   typedef struct packed {
      logic diff_en;
      logic mul_en;
      logic prod_en;
   } lane_ctl_type;

   // handshake between the main sequencer and the root unit
   typedef struct packed {
      logic start;
      logic take;
   } sqrt_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

>>> rtl/core/rmsdma_lane.sv
`timescale 1ns / 1ps

module rmsdma_lane (
   input  logic                                clock,
   input  rmsdma_pkg::lane_ctl_type            ctl,
   input  rmsdma_pkg::coord_type               avg_in,
   input  rmsdma_pkg::coord_type               pos_in,
   input  logic [rmsdma_pkg::WEIGHT_W-1:0]     weight,
   output logic [rmsdma_pkg::SQ_W-1:0]         sq_out,
   output rmsdma_pkg::coord_type               blend_out,
   output logic                                sat_out
);
   import rmsdma_pkg::*;

   localparam coord_type POS_MAX = 24'sh7FFFFF;
   localparam coord_type POS_MIN = 24'sh800000;

   logic signed [POS_W:0]     diff_wide;
   coord_type                 diff_in;
   logic                      sat_in;
   logic [WEIGHT_W-1:0]       inv_weight;
   logic signed [47:0]        sq_full;
   logic signed [41:0]        avg_prod_in;
   logic signed [41:0]        pos_prod_in;
   logic signed [42:0]        blend_sum;

   coord_type                 diff_ff;
   coord_type                 avg_ff;
   logic                      sat_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic signed [41:0]        avg_prod_ff;
   logic signed [41:0]        pos_prod_ff;

   // saturate the difference avg - pos to the coordinate range
   assign diff_wide = {avg_in[POS_W-1], avg_in} - {pos_in[POS_W-1], pos_in};
   always_comb begin
      sat_in  = diff_wide[POS_W] != diff_wide[POS_W-1];
      diff_in = diff_wide[POS_W-1:0];
      if (sat_in) begin
         diff_in = diff_wide[POS_W] ? POS_MIN : POS_MAX;
      end
   end

   // square of the difference and the two blend products
   assign inv_weight  = ONE_Q16 - weight;
   assign sq_full     = 48'(diff_ff) * 48'(diff_ff);
   assign avg_prod_in = 42'(avg_ff) * 42'($signed({1'b0, inv_weight}));
   assign pos_prod_in = 42'(pos_in) * 42'($signed({1'b0, weight}));

   always_ff @(posedge clock) begin
      if (ctl.diff_en) begin
         diff_ff <= diff_in;
         avg_ff  <= avg_in;
         sat_ff  <= sat_in;
      end
      if (ctl.mul_en) begin
         sq_ff       <= sq_full[SQ_W-1:0];
         avg_prod_ff <= avg_prod_in;
      end
      if (ctl.prod_en) begin
         pos_prod_ff <= pos_prod_in;
      end
   end

   // new average rounds toward minus infinity: arithmetic shift by 16
   assign blend_sum = 43'(avg_prod_ff) + 43'(pos_prod_ff);
   assign blend_out = blend_sum[39:16];
   assign sq_out    = sq_ff;
   assign sat_out   = sat_ff;

endmodule

>>> rtl/core/rmsdma_sqrt.sv
`timescale 1ns / 1ps

module rmsdma_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  rmsdma_pkg::sqrt_ctl_type           ctl,
   input  logic [rmsdma_pkg::SUM_W-1:0]       sum_in,
   input  logic                               ovf_in,
   input  logic [rmsdma_pkg::TIME_W-1:0]      time_in,
   output rmsdma_pkg::sqrt_stat_type          stat,
   output logic [rmsdma_pkg::RMSD_W-1:0]      root_out,
   output logic                               sat_out,
   output logic [rmsdma_pkg::TIME_W-1:0]      time_out
);
   import rmsdma_pkg::*;

   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_RUN  = 2'd1;
   localparam logic [1:0] SQ_DONE = 2'd2;
   localparam int REM_W = 36;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rad_ff;
   logic [REM_W-3:0]     rem_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic                 ovf_ff;
   logic [TIME_W-1:0]    time_ff;

   logic [REM_W-1:0]     rem_shift;
   logic [REM_W-1:0]     trial;
   logic [REM_W-1:0]     rem_sub;
   logic                 fits;

   // one result bit a cycle: bring down two radicand bits, try root*4+1
   assign rem_shift = {rem_ff, rad_ff[SUM_W-1:SUM_W-2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign rem_sub   = rem_shift - trial;
   assign fits      = rem_shift >= trial;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (ctl.start) begin
               state_in = SQ_RUN;
               cnt_in   = CNT_W'(ROOT_W - 1);
            end
         end
         SQ_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = SQ_DONE;
            end
         end
         SQ_DONE: begin
            if (ctl.take) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // hold the radicand, partial remainder and root
   always_ff @(posedge clock) begin
      if (state_ff == SQ_IDLE && ctl.start) begin
         rad_ff  <= sum_in;
         rem_ff  <= '0;
         root_ff <= '0;
         ovf_ff  <= ovf_in;
         time_ff <= time_in;
      end else if (state_ff == SQ_RUN) begin
         rad_ff <= {rad_ff[SUM_W-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= rem_sub[REM_W-3:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[REM_W-3:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // clamp the root to the output range
   assign stat.busy = state_ff != SQ_IDLE;
   assign stat.done = state_ff == SQ_DONE;
   assign root_out  = (root_ff[ROOT_W-1:RMSD_W] != '0) ? RMSD_MAX : root_ff[RMSD_W-1:0];
   assign sat_out   = ovf_ff || (root_ff[ROOT_W-1:RMSD_W] != '0);
   assign time_out  = time_ff;

endmodule

>>> rtl/core/rmsd_from_moving_average.sv
`timescale 1ns / 1ps

// Moving-average RMSD engine.
// req_ carries one atom position per transaction with its slot. Mode 0 loads
// the slot's reference average; mode 1 adds the squared distance from the
// stored average to the frame sum and blends the position into the average
// with weight csr_wr_data (Q1.16, values above one act as one).
// A load transaction passes through ADDR, a measure transaction through ADDR,
// DIFF, MUL, PROD and ACC; req_stall stays high until the sequencer is idle.
// A measure transaction with frame_end hands the frame sum to a one-bit-per-
// cycle square-root unit (in ROOT, which waits while the unit is still busy)
// and clears the sum; rsp_valid rises once the unit has finished and its result
// is taken into the output register. The root unit works while the next frame
// streams in. rsp_ is a registered output: while rsp_stall is high the result
// holds and one more finished root waits in the root unit, after which frame
// ends back up into req_stall.
// Reset (synchronous) clears the frame sum, the overflow flag and the weight
// to 62259; the average memory is not cleared and must be loaded first. The
// configuration register must be written only while the block is idle; not enforced.
module rmsd_from_moving_average #(
   parameter int MAX_ATOMS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [rmsdma_pkg::SLOT_W-1:0]      req_slot,
   input  logic signed [rmsdma_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [rmsdma_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [rmsdma_pkg::POS_W-1:0] req_pos_z,
   input  logic                               req_frame_end,
   input  logic [rmsdma_pkg::TIME_W-1:0]      req_frame_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rmsdma_pkg::RMSD_W-1:0]      rsp_rmsd_value,
   output logic [rmsdma_pkg::TIME_W-1:0]      rsp_time_step,
   output logic                               rsp_saturated,
   input  logic                               csr_wr_en,
   input  logic [rmsdma_pkg::WEIGHT_W-1:0]    csr_wr_data
);
   import rmsdma_pkg::*;

   localparam int ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int RECIP  = ((1 << RECIP_SHIFT) + MAX_ATOMS - 1) / MAX_ATOMS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADDR = 3'd1;
   localparam logic [2:0] S_DIFF = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_PROD = 3'd4;
   localparam logic [2:0] S_ACC  = 3'd5;
   localparam logic [2:0] S_ROOT = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [WEIGHT_W-1:0]   blend_ff, blend_in;
   logic [SUM_W-1:0]      frame_sum_ff, frame_sum_in;
   logic                  sum_ovf_ff, sum_ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // transaction payload
   logic                  mode_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     quo_ff;
   coord_type             pos_x_ff, pos_y_ff, pos_z_ff;
   logic                  end_ff;
   logic [TIME_W-1:0]     time_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [D2_W-1:0]       d2_ff;
   logic [RMSD_W-1:0]     rsp_value_ff;
   logic [TIME_W-1:0]     rsp_time_ff;
   logic                  rsp_sat_ff;

   logic                  req_accept;
   logic [30:0]           quo_prod;
   logic [26:0]           slot_rem;
   logic [ADDR_W-1:0]     addr_in;
   logic [WEIGHT_W-1:0]   weight;

   // average memory
   avg_word_type          avg_mem [MAX_ATOMS];
   avg_word_type          mem_rdata_ff;
   avg_word_type          mem_wdata;
   logic [ADDR_W-1:0]     mem_addr;
   logic                  mem_we;
   logic                  mem_re;

   lane_ctl_type          lane_ctl;
   logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
   coord_type             new_x, new_y, new_z;
   logic                  sat_x, sat_y, sat_z;
   logic [SUM_W:0]        sum_wide;

   sqrt_ctl_type          sq_ctl;
   sqrt_stat_type         sq_stat;
   logic [RMSD_W-1:0]     root_val;
   logic                  root_sat;
   logic [TIME_W-1:0]     root_time;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;

   // slot modulo depth: quotient by reciprocal, registered; remainder in the cycle after
   assign quo_prod = 31'(req_slot) * 31'(RECIP);
   assign slot_rem = 27'(slot_ff) - 27'(quo_ff) * 27'(MAX_ATOMS);
   assign addr_in  = slot_rem[ADDR_W-1:0];

   assign weight = (blend_ff > ONE_Q16) ? ONE_Q16 : blend_ff;

   // capture the transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_mode;
         slot_ff  <= req_slot;
         quo_ff   <= quo_prod[RECIP_SHIFT+SLOT_W-1:RECIP_SHIFT];
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
         end_ff   <= req_frame_end;
         time_ff  <= req_frame_time;
      end
      if (state_ff == S_ADDR) begin
         addr_ff <= addr_in;
      end
      if (state_ff == S_PROD) begin
         d2_ff <= D2_W'(sq_x) + D2_W'(sq_y) + D2_W'(sq_z);
      end
   end

   // memory port: load writes in ADDR, measure reads in ADDR and writes back in ACC;
   // the sequencer never overlaps two transactions, so no forwarding is needed
   assign mem_we    = (state_ff == S_ADDR && !mode_ff) || state_ff == S_ACC;
   assign mem_re    = state_ff == S_ADDR && mode_ff;
   assign mem_addr  = (state_ff == S_ACC) ? addr_ff : addr_in;
   assign mem_wdata = (state_ff == S_ACC) ? avg_word_type'{new_x, new_y, new_z}
                                          : avg_word_type'{pos_x_ff, pos_y_ff, pos_z_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         avg_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= avg_mem[mem_addr];
      end
   end

   // per-axis difference, square and blend
   assign lane_ctl.diff_en = state_ff == S_DIFF;
   assign lane_ctl.mul_en  = state_ff == S_MUL;
   assign lane_ctl.prod_en = state_ff == S_PROD;

   rmsdma_lane u_lane_x (
      .clock     (clock),
      .ctl       (lane_ctl),
      .avg_in    (mem_rdata_ff.x),
      .pos_in    (pos_x_ff),
      .weight    (weight),
      .sq_out    (sq_x),
      .blend_out (new_x),
      .sat_out   (sat_x)
   );

   rmsdma_lane u_lane_y (
      .clock     (clock),
      .ctl       (lane_ctl),
      .avg_in    (mem_rdata_ff.y),
      .pos_in    (pos_y_ff),
      .weight    (weight),
      .sq_out    (sq_y),
      .blend_out (new_y),
      .sat_out   (sat_y)
   );

   rmsdma_lane u_lane_z (
      .clock     (clock),
      .ctl       (lane_ctl),
      .avg_in    (mem_rdata_ff.z),
      .pos_in    (pos_z_ff),
      .weight    (weight),
      .sq_out    (sq_z),
      .blend_out (new_z),
      .sat_out   (sat_z)
   );

   // saturating frame accumulation
   assign sum_wide = {1'b0, frame_sum_ff} + (SUM_W + 1)'(d2_ff);

   // root unit handoff
   assign sq_ctl.start = state_ff == S_ROOT && !sq_stat.busy;
   assign sq_ctl.take  = sq_stat.done && (!rsp_valid_ff || !rsp_stall);

   rmsdma_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sq_ctl),
      .sum_in   (frame_sum_ff),
      .ovf_in   (sum_ovf_ff),
      .time_in  (time_ff),
      .stat     (sq_stat),
      .root_out (root_val),
      .sat_out  (root_sat),
      .time_out (root_time)
   );

   // sequencer and frame state
   always_comb begin
      state_in     = state_ff;
      frame_sum_in = frame_sum_ff;
      sum_ovf_in   = sum_ovf_ff;
      blend_in     = csr_wr_en ? csr_wr_data : blend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: state_in = mode_ff ? S_DIFF : S_IDLE;
         S_DIFF: state_in = S_MUL;
         S_MUL:  state_in = S_PROD;
         S_PROD: state_in = S_ACC;
         S_ACC: begin
            frame_sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            sum_ovf_in   = sum_ovf_ff || sat_x || sat_y || sat_z || sum_wide[SUM_W];
            state_in     = end_ff ? S_ROOT : S_IDLE;
         end
         S_ROOT: begin
            if (sq_ctl.start) begin
               frame_sum_in = '0;
               sum_ovf_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: load from the root unit, drop on acceptance
   assign rsp_valid_in = sq_ctl.take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         blend_ff     <= WEIGHT_RESET;
         frame_sum_ff <= '0;
         sum_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blend_ff     <= blend_in;
         frame_sum_ff <= frame_sum_in;
         sum_ovf_ff   <= sum_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_ctl.take) begin
         rsp_value_ff <= root_val;
         rsp_time_ff  <= root_time;
         rsp_sat_ff   <= root_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rmsd_value = rsp_value_ff;
   assign rsp_time_step  = rsp_time_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // checks
   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("average memory read and write in the same cycle");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.start |-> !sq_stat.busy)
      else $error("root unit started while busy");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.start |=> (frame_sum_ff == '0 && !sum_ovf_ff))
      else $error("frame sum not cleared after handoff");

   a_take_done: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.take |-> (sq_stat.done && !sq_ctl.start))
      else $error("result taken from root unit that is not done");

endmodule
